// ===== hdl/drive_power_state_machine_top_assert.svh =====
// ----------------------------------------------------------------------------
// Drive power state machine assertion macros
// Concurrent checks for the top level; define NO_ASSERTIONS to drop them.
// ----------------------------------------------------------------------------
`ifndef DRIVE_POWER_STATE_MACHINE_TOP_ASSERT_SVH
`define DRIVE_POWER_STATE_MACHINE_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Condition on this edge implies expression on this edge
`define DPSM_ASSERT_IMPLY(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error("assertion failed: cond implies expr");

// Condition on this edge implies expression on the next edge
`define DPSM_ASSERT_NEXT(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error("assertion failed: cond implies expr one cycle later");

`else

`define DPSM_ASSERT_IMPLY(label, clk, rst, cond, expr)
`define DPSM_ASSERT_NEXT(label, clk, rst, cond, expr)

`endif

`endif

// ===== hdl/dpsm_pkg.sv =====
// ----------------------------------------------------------------------------
// Drive power state machine package
// State encoding, controlword decode masks and statusword lookup.
// ----------------------------------------------------------------------------
`default_nettype none

package dpsm_pkg;

   // Drive state codes as shown on the state_code output
   typedef enum logic [2:0] {
      ST_NOT_READY = 3'd0,
      ST_DISABLED  = 3'd1,
      ST_READY     = 3'd2,
      ST_ON        = 3'd3,
      ST_ENABLED   = 3'd4,
      ST_QSTOP     = 3'd5,
      ST_REACTION  = 3'd6,
      ST_FAULT     = 3'd7
   } drive_state_type;

   // Controlword command masks and patterns
   localparam logic [15:0] CW_DIS_VOLT_MASK = 16'h0082;
   localparam logic [15:0] CW_DIS_VOLT_PAT  = 16'h0000;
   localparam logic [15:0] CW_SHUT_MASK     = 16'h0087;
   localparam logic [15:0] CW_SHUT_PAT      = 16'h0006;
   localparam logic [15:0] CW_SW_ON_MASK    = 16'h008F;
   localparam logic [15:0] CW_SW_ON_PAT     = 16'h0007;
   localparam logic [15:0] CW_EN_OP_MASK    = 16'h008F;
   localparam logic [15:0] CW_EN_OP_PAT     = 16'h000F;
   localparam logic [15:0] CW_QSTOP_MASK    = 16'h0086;
   localparam logic [15:0] CW_QSTOP_PAT     = 16'h0002;

   // Fault reset bit of the controlword
   localparam int unsigned CW_FAULT_RESET_BIT = 7;

   // Statusword encodings
   localparam logic [6:0] SW_NOT_READY = 7'h00;
   localparam logic [6:0] SW_DISABLED  = 7'h40;
   localparam logic [6:0] SW_READY     = 7'h21;
   localparam logic [6:0] SW_ON        = 7'h23;
   localparam logic [6:0] SW_ENABLED   = 7'h27;
   localparam logic [6:0] SW_QSTOP     = 7'h07;
   localparam logic [6:0] SW_REACTION  = 7'h0F;
   localparam logic [6:0] SW_FAULT     = 7'h08;

   // Map a drive state to its statusword
   function automatic logic [6:0] status_of(input drive_state_type st);
      logic [6:0] sw;
      unique case (st)
         ST_NOT_READY: sw = SW_NOT_READY;
         ST_DISABLED:  sw = SW_DISABLED;
         ST_READY:     sw = SW_READY;
         ST_ON:        sw = SW_ON;
         ST_ENABLED:   sw = SW_ENABLED;
         ST_QSTOP:     sw = SW_QSTOP;
         ST_REACTION:  sw = SW_REACTION;
         ST_FAULT:     sw = SW_FAULT;
         default:      sw = SW_NOT_READY;
      endcase
      return sw;
   endfunction

endpackage

`default_nettype wire

// ===== hdl/dpsm_req_if.sv =====
// ----------------------------------------------------------------------------
// Drive power state machine request channel
// Valid/ready channel carrying one controlword item per word.
// ----------------------------------------------------------------------------
`default_nettype none

interface dpsm_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] control_word;
   logic        fault_report;
   logic [7:0]  operation_mode;

   modport source (output valid, output control_word, output fault_report,
                   output operation_mode, input ready);
   modport sink   (input valid, input control_word, input fault_report,
                   input operation_mode, output ready);
endinterface

`default_nettype wire

// ===== hdl/dpsm_rsp_if.sv =====
// ----------------------------------------------------------------------------
// Drive power state machine response channel
// Valid/ready channel carrying one statusword result per word.
// ----------------------------------------------------------------------------
`default_nettype none

interface dpsm_rsp_if;
   logic       valid;
   logic       ready;
   logic [6:0] status_word;
   logic [2:0] state_code;
   logic [7:0] shown_mode;

   modport source (output valid, output status_word, output state_code,
                   output shown_mode, input ready);
   modport sink   (input valid, input status_word, input state_code,
                   input shown_mode, output ready);
endinterface

`default_nettype wire

// ===== hdl/drive_power_state_machine_top.sv =====
// ----------------------------------------------------------------------------
// Drive power state machine
// Drive-side power state machine: controlword decode, fault latch and
// statusword generation.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan takes one word per item: controlword, fault report bit and the
//   requested operation mode. rsp_chan returns one word per item: the
//   statusword of the new state, the state code and the displayed mode
//   (zero while the result is Fault by a held or reported fault).
//   Each word passes an input register and then a result register before
//   its result appears on rsp_chan. One item is taken every cycle while
//   rsp_chan.ready is high; the drive state updates as the item leaves the
//   input register, so the next item already sees the new state.
//   Reset (synchronous, active high) empties both registers, sets the state
//   to switch-on disabled and clears the fault latch.
//   When rsp_chan.ready is low, the result holds; the input register still
//   accepts one more word, after which req_chan.ready drops until the
//   result is taken.
// ----------------------------------------------------------------------------
`default_nettype none

`include "drive_power_state_machine_top_assert.svh"

module drive_power_state_machine_top (
   input wire logic   clock,
   input wire logic   reset,
   dpsm_req_if.sink   req_chan,
   dpsm_rsp_if.source rsp_chan
);

   // Input register
   logic        in_valid_ff;
   logic        in_valid_in;
   logic [15:0] in_cw_ff;
   logic        in_fault_ff;
   logic [7:0]  in_mode_ff;

   // Result register
   logic        out_valid_ff;
   logic        out_valid_in;
   logic [6:0]  out_status_ff;
   logic [2:0]  out_code_ff;
   logic [7:0]  out_mode_ff;

   // Drive state
   dpsm_pkg::drive_state_type drive_state_ff;
   dpsm_pkg::drive_state_type drive_state_in;
   logic                      fault_latched_ff;
   logic                      fault_latched_in;

   // Transition logic
   dpsm_pkg::drive_state_type state_pre;
   dpsm_pkg::drive_state_type state_new;
   logic                      fault_new;
   logic                      faulted;
   logic                      dis_volt;
   logic                      shut;
   logic                      sw_on;
   logic                      en_op;
   logic                      qstop;

   // Handshake
   logic out_advance;
   logic in_take;
   logic req_take;

   assign out_advance = !out_valid_ff || rsp_chan.ready;
   assign in_take     = in_valid_ff && out_advance;
   assign req_chan.ready = !in_valid_ff || out_advance;
   assign req_take    = req_chan.valid && req_chan.ready;

   // Decode controlword commands
   assign dis_volt = (in_cw_ff & dpsm_pkg::CW_DIS_VOLT_MASK) == dpsm_pkg::CW_DIS_VOLT_PAT;
   assign shut     = (in_cw_ff & dpsm_pkg::CW_SHUT_MASK) == dpsm_pkg::CW_SHUT_PAT;
   assign sw_on    = (in_cw_ff & dpsm_pkg::CW_SW_ON_MASK) == dpsm_pkg::CW_SW_ON_PAT;
   assign en_op    = (in_cw_ff & dpsm_pkg::CW_EN_OP_MASK) == dpsm_pkg::CW_EN_OP_PAT;
   assign qstop    = (in_cw_ff & dpsm_pkg::CW_QSTOP_MASK) == dpsm_pkg::CW_QSTOP_PAT;

   // Next state and fault latch
   always_comb begin
      faulted   = 1'b0;
      fault_new = fault_latched_ff;
      state_pre = drive_state_ff;

      // Fault handling takes precedence over command decode
      priority if (in_fault_ff) begin
         fault_new = 1'b1;
         state_pre = dpsm_pkg::ST_FAULT;
         faulted   = 1'b1;
      end else if (fault_latched_ff) begin
         if (in_cw_ff[dpsm_pkg::CW_FAULT_RESET_BIT]) begin
            fault_new = 1'b0;
            state_pre = dpsm_pkg::ST_DISABLED;
         end else begin
            state_pre = dpsm_pkg::ST_FAULT;
            faulted   = 1'b1;
         end
      end else begin
         state_pre = drive_state_ff;
      end

      // Prioritized command transitions
      state_new = state_pre;
      if (!faulted) begin
         priority if (dis_volt) begin
            state_new = dpsm_pkg::ST_DISABLED;
         end else if (state_pre == dpsm_pkg::ST_DISABLED && shut) begin
            state_new = dpsm_pkg::ST_READY;
         end else if (state_pre == dpsm_pkg::ST_READY && sw_on) begin
            state_new = dpsm_pkg::ST_ON;
         end else if ((state_pre == dpsm_pkg::ST_ON || state_pre == dpsm_pkg::ST_QSTOP)
                      && en_op) begin
            state_new = dpsm_pkg::ST_ENABLED;
         end else if (state_pre == dpsm_pkg::ST_ENABLED && sw_on) begin
            state_new = dpsm_pkg::ST_ON;
         end else if (state_pre == dpsm_pkg::ST_ENABLED && qstop) begin
            state_new = dpsm_pkg::ST_QSTOP;
         end else if ((state_pre == dpsm_pkg::ST_ON || state_pre == dpsm_pkg::ST_ENABLED)
                      && shut) begin
            state_new = dpsm_pkg::ST_READY;
         end else begin
            state_new = state_pre;
         end
      end

      // Commit only when the item moves on
      drive_state_in   = in_take ? state_new : drive_state_ff;
      fault_latched_in = in_take ? fault_new : fault_latched_ff;
      in_valid_in      = req_chan.ready ? req_chan.valid : in_valid_ff;
      out_valid_in     = out_advance ? in_valid_ff : out_valid_ff;
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff      <= 1'b0;
         out_valid_ff     <= 1'b0;
         drive_state_ff   <= dpsm_pkg::ST_DISABLED;
         fault_latched_ff <= 1'b0;
      end else begin
         in_valid_ff      <= in_valid_in;
         out_valid_ff     <= out_valid_in;
         drive_state_ff   <= drive_state_in;
         fault_latched_ff <= fault_latched_in;
      end
   end

   // Capture request word
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_cw_ff    <= req_chan.control_word;
         in_fault_ff <= req_chan.fault_report;
         in_mode_ff  <= req_chan.operation_mode;
      end
   end

   // Load result word
   always_ff @(posedge clock) begin
      if (in_take) begin
         out_status_ff <= dpsm_pkg::status_of(state_new);
         out_code_ff   <= 3'(state_new);
         out_mode_ff   <= faulted ? 8'd0 : in_mode_ff;
      end
   end

   assign rsp_chan.valid        = out_valid_ff;
   assign rsp_chan.status_word  = out_status_ff;
   assign rsp_chan.state_code   = out_code_ff;
   assign rsp_chan.shown_mode   = out_mode_ff;

   // Checks
   `DPSM_ASSERT_IMPLY(a_fault_latch_state, clock, reset, fault_latched_ff, drive_state_ff == dpsm_pkg::ST_FAULT)
   `DPSM_ASSERT_IMPLY(a_no_unreached_state, clock, reset, 1'b1, drive_state_ff != dpsm_pkg::ST_NOT_READY && drive_state_ff != dpsm_pkg::ST_REACTION)
   `DPSM_ASSERT_IMPLY(a_fault_mode_zero, clock, reset, out_valid_ff && out_code_ff == dpsm_pkg::ST_FAULT, out_mode_ff == 8'd0)
   `DPSM_ASSERT_NEXT(a_report_latches, clock, reset, in_take && in_fault_ff, fault_latched_ff)

endmodule

`default_nettype wire
